FILE: rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the stack machine execute core: opcodes,
// fault codes, beat layouts and the control word handed from decode to the
// datapath.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int WORD_W    = 32;
    localparam int OP_W      = 4;
    localparam int ARG_W     = 32;
    localparam int NEXT_PC_W = 10;
    localparam int FAULT_W   = 3;
    localparam int VALUE_W   = 32;

    // s_tdata: op, arg, zero pad
    localparam int S_TDATA_W = 40;
    // m_tdata: next_pc, halted, print_valid, print_value, fault, zero pad
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_NOP  = 4'd0,
        OP_PUSH = 4'd1,
        OP_LOAD = 4'd2,
        OP_STR  = 4'd3,
        OP_POP  = 4'd4,
        OP_ADD  = 4'd5,
        OP_SUB  = 4'd6,
        OP_MUL  = 4'd7,
        OP_HLT  = 4'd8,
        OP_JMP  = 4'd9,
        OP_IFZ  = 4'd10,
        OP_IFP  = 4'd11,
        OP_IFN  = 4'd12,
        OP_PRI  = 4'd13,
        OP_PRB  = 4'd14
    } op_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE      = 3'd0,
        FAULT_UNDERFLOW = 3'd1,
        FAULT_OVERFLOW  = 3'd2,
        FAULT_INDEX     = 3'd3,
        FAULT_OPCODE    = 3'd4
    } fault_t;

    typedef enum logic [1:0] {
        WA_SP,
        WA_SP2,
        WA_ARG
    } wr_addr_sel_t;

    typedef enum logic [1:0] {
        WD_IMM,
        WD_OPA,
        WD_ALU
    } wr_data_sel_t;

    typedef enum logic [1:0] {
        SP_HOLD,
        SP_PUSH,
        SP_POP
    } sp_step_t;

    typedef enum logic [1:0] {
        PC_HOLD,
        PC_INC,
        PC_JUMP
    } pc_step_t;

    typedef struct packed {
        logic         wr_en;
        wr_addr_sel_t wr_addr_sel;
        wr_data_sel_t wr_data_sel;
        sp_step_t     sp_step;
        pc_step_t     pc_step;
        logic         halted;
        logic         print_valid;
        logic         print_is_bool;
        fault_t       fault;
    } exec_ctl_t;

endpackage

FILE: rtl/smx_stack_ram.sv
// ----------------------------------------------------------------------------
// smx_stack_ram
// Data stack storage: one write port and two read ports, read data
// registered on the read enable.
// ----------------------------------------------------------------------------
module smx_stack_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr_a,
    input  logic [AW-1:0]             rd_addr_b,
    output logic [smx_pkg::WORD_W-1:0] rd_data_a,
    output logic [smx_pkg::WORD_W-1:0] rd_data_b,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [smx_pkg::WORD_W-1:0] wr_data
);

    logic [smx_pkg::WORD_W-1:0] mem [DEPTH];
    logic [smx_pkg::WORD_W-1:0] rd_data_a_reg;
    logic [smx_pkg::WORD_W-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write; same-cycle collisions are forwarded by the caller
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: rtl/smx_exec.sv
// ----------------------------------------------------------------------------
// smx_exec
// Instruction decode, fault checks, branch decision and arithmetic for the
// instruction in the execute stage.
// ----------------------------------------------------------------------------
module smx_exec #(
    parameter int STACK_DEPTH  = 256,
    parameter int PROGRAM_SIZE = 1024,
    parameter int SPW          = 9
) (
    input  logic [smx_pkg::OP_W-1:0]    op,
    input  logic signed [smx_pkg::ARG_W-1:0] arg,
    input  logic [SPW-1:0]              sp,
    input  logic [smx_pkg::WORD_W-1:0]  opnd_a,
    input  logic [smx_pkg::WORD_W-1:0]  opnd_b,
    output smx_pkg::exec_ctl_t          ctl,
    output logic [smx_pkg::WORD_W-1:0]  alu_res
);

    logic full;
    logic lt1;
    logic lt2;
    logic idx_ok;
    logic tgt_ok;
    logic take;
    smx_pkg::fault_t fault;
    smx_pkg::exec_ctl_t ok_ctl;

    assign full   = (sp >= SPW'(STACK_DEPTH));
    assign lt1    = (sp == '0);
    assign lt2    = (sp < SPW'(2));
    assign idx_ok = !arg[smx_pkg::ARG_W-1] && ($unsigned(arg) < 32'(sp));
    assign tgt_ok = !arg[smx_pkg::ARG_W-1] && ($unsigned(arg) < 32'(PROGRAM_SIZE));

    always_comb begin
        case (smx_pkg::op_t'(op))
            smx_pkg::OP_IFZ: take = (opnd_a == '0);
            smx_pkg::OP_IFP: take = !opnd_a[smx_pkg::WORD_W-1];
            smx_pkg::OP_IFN: take = opnd_a[smx_pkg::WORD_W-1];
            default:         take = 1'b0;
        endcase
    end

    // b is the entry below the top, a the top
    always_comb begin
        case (smx_pkg::op_t'(op))
            smx_pkg::OP_ADD: alu_res = opnd_b + opnd_a;
            smx_pkg::OP_SUB: alu_res = opnd_b - opnd_a;
            default:         alu_res = opnd_b * opnd_a;
        endcase
    end

    always_comb begin
        fault  = smx_pkg::FAULT_NONE;
        ok_ctl = '{wr_en: 1'b0, wr_addr_sel: smx_pkg::WA_SP, wr_data_sel: smx_pkg::WD_IMM,
                   sp_step: smx_pkg::SP_HOLD, pc_step: smx_pkg::PC_INC, halted: 1'b0,
                   print_valid: 1'b0, print_is_bool: 1'b0, fault: smx_pkg::FAULT_NONE};
        case (smx_pkg::op_t'(op))
            smx_pkg::OP_NOP: begin
            end
            smx_pkg::OP_PUSH: begin
                if (full) fault = smx_pkg::FAULT_OVERFLOW;
                ok_ctl.wr_en   = 1'b1;
                ok_ctl.sp_step = smx_pkg::SP_PUSH;
            end
            smx_pkg::OP_LOAD: begin
                if (full) fault = smx_pkg::FAULT_OVERFLOW;
                else if (!idx_ok) fault = smx_pkg::FAULT_INDEX;
                ok_ctl.wr_en       = 1'b1;
                ok_ctl.wr_data_sel = smx_pkg::WD_OPA;
                ok_ctl.sp_step     = smx_pkg::SP_PUSH;
            end
            smx_pkg::OP_STR: begin
                if (lt1) fault = smx_pkg::FAULT_UNDERFLOW;
                else if (!idx_ok) fault = smx_pkg::FAULT_INDEX;
                ok_ctl.wr_en       = 1'b1;
                ok_ctl.wr_addr_sel = smx_pkg::WA_ARG;
                ok_ctl.wr_data_sel = smx_pkg::WD_OPA;
                ok_ctl.sp_step     = smx_pkg::SP_POP;
            end
            smx_pkg::OP_POP: begin
                if (lt1) fault = smx_pkg::FAULT_UNDERFLOW;
                ok_ctl.sp_step = smx_pkg::SP_POP;
            end
            smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL: begin
                if (lt2) fault = smx_pkg::FAULT_UNDERFLOW;
                ok_ctl.wr_en       = 1'b1;
                ok_ctl.wr_addr_sel = smx_pkg::WA_SP2;
                ok_ctl.wr_data_sel = smx_pkg::WD_ALU;
                ok_ctl.sp_step     = smx_pkg::SP_POP;
            end
            smx_pkg::OP_HLT: begin
                ok_ctl.pc_step = smx_pkg::PC_HOLD;
                ok_ctl.halted  = 1'b1;
            end
            smx_pkg::OP_JMP: begin
                if (!tgt_ok) fault = smx_pkg::FAULT_INDEX;
                ok_ctl.pc_step = smx_pkg::PC_JUMP;
            end
            smx_pkg::OP_IFZ, smx_pkg::OP_IFP, smx_pkg::OP_IFN: begin
                if (lt1) fault = smx_pkg::FAULT_UNDERFLOW;
                else if (take && !tgt_ok) fault = smx_pkg::FAULT_INDEX;
                ok_ctl.sp_step = smx_pkg::SP_POP;
                ok_ctl.pc_step = take ? smx_pkg::PC_JUMP : smx_pkg::PC_INC;
            end
            smx_pkg::OP_PRI, smx_pkg::OP_PRB: begin
                if (lt1) fault = smx_pkg::FAULT_UNDERFLOW;
                ok_ctl.sp_step       = smx_pkg::SP_POP;
                ok_ctl.print_valid   = 1'b1;
                ok_ctl.print_is_bool = (smx_pkg::op_t'(op) == smx_pkg::OP_PRB);
            end
            default: begin
                fault = smx_pkg::FAULT_OPCODE;
            end
        endcase
    end

    // a faulting instruction changes nothing and halts
    always_comb begin
        if (fault != smx_pkg::FAULT_NONE) begin
            ctl = '{wr_en: 1'b0, wr_addr_sel: smx_pkg::WA_SP, wr_data_sel: smx_pkg::WD_IMM,
                    sp_step: smx_pkg::SP_HOLD, pc_step: smx_pkg::PC_HOLD, halted: 1'b1,
                    print_valid: 1'b0, print_is_bool: 1'b0, fault: fault};
        end else begin
            ctl = ok_ctl;
        end
    end

endmodule

FILE: rtl/stack_machine_execute_core.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_core
// Execute unit of a small stack virtual machine: data stack in RAM, stack
// pointer and program counter in registers, one result beat per instruction.
//
//   channel | dir | beat contents
//   s_      | in  | tdata: op[3:0], arg[35:4]
//   m_      | out | tdata: next_pc[9:0], halted[10], print_valid[11],
//           |     |        print_value[43:12], fault[46:44]; tuser: print_is_bool
//
// An instruction enters at the s_ beat, reads up to two stack words from the
// RAM in that cycle and executes in the execute stage, where the result
// beat is registered and the write-back happens. Throughput is one
// instruction per cycle while the m_ side does not stall; the RAM read data
// is registered, and a write-back to the address being read is forwarded.
// Reset clears the stack pointer and program counter; the stack RAM is not
// cleared. A stalled m_ side holds the execute stage and the s_ side.
// ----------------------------------------------------------------------------
module stack_machine_execute_core #(
    parameter int STACK_DEPTH  = 256,
    parameter int PROGRAM_SIZE = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [smx_pkg::S_TDATA_W-1:0]    s_tdata,   // op, arg
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [smx_pkg::M_TDATA_W-1:0]    m_tdata,   // next_pc, halted, print_valid,
                                                        // print_value, fault
    output logic [smx_pkg::M_TUSER_W-1:0]    m_tuser    // print_is_bool
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int PCW = $clog2(PROGRAM_SIZE);

    logic [smx_pkg::OP_W-1:0]           s_op;
    logic signed [smx_pkg::ARG_W-1:0]   s_arg;
    logic                               s_fire;
    logic                               x_fire;

    logic                               x_valid_reg;
    logic [smx_pkg::OP_W-1:0]           x_op_reg;
    logic signed [smx_pkg::ARG_W-1:0]   x_arg_reg;
    logic [SPW-1:0]                     sp_reg;
    logic [SPW-1:0]                     sp_next;
    logic [PCW-1:0]                     pc_reg;
    logic [PCW-1:0]                     pc_next;
    logic [PCW-1:0]                     pc_inc;
    logic                               fwd_a_reg;
    logic                               fwd_b_reg;
    logic [smx_pkg::WORD_W-1:0]         fwd_data_reg;

    logic                               m_valid_reg;
    logic [smx_pkg::M_TDATA_W-1:0]      m_tdata_reg;
    logic [smx_pkg::M_TUSER_W-1:0]      m_tuser_reg;

    logic [AW-1:0]                      rd_addr_a;
    logic [AW-1:0]                      rd_addr_b;
    logic [smx_pkg::WORD_W-1:0]         rd_data_a;
    logic [smx_pkg::WORD_W-1:0]         rd_data_b;
    logic [smx_pkg::WORD_W-1:0]         opnd_a;
    logic [smx_pkg::WORD_W-1:0]         opnd_b;
    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [smx_pkg::WORD_W-1:0]         wr_data;
    logic [smx_pkg::WORD_W-1:0]         alu_res;
    logic [SPW-1:0]                     sp_m1;
    logic [SPW-1:0]                     sp_m2;
    logic [SPW-1:0]                     sp_next_m1;
    logic [SPW-1:0]                     sp_next_m2;
    logic [smx_pkg::VALUE_W-1:0]        print_value;
    smx_pkg::exec_ctl_t                 ctl;

    assign s_op  = s_tdata[smx_pkg::OP_W-1:0];
    assign s_arg = $signed(s_tdata[smx_pkg::OP_W +: smx_pkg::ARG_W]);

    assign x_fire   = x_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !x_valid_reg || x_fire;
    assign s_fire   = s_tvalid && s_tready;

    assign opnd_a = fwd_a_reg ? fwd_data_reg : rd_data_a;
    assign opnd_b = fwd_b_reg ? fwd_data_reg : rd_data_b;

    smx_exec #(
        .STACK_DEPTH  (STACK_DEPTH),
        .PROGRAM_SIZE (PROGRAM_SIZE),
        .SPW          (SPW)
    ) u_exec (
        .op      (x_op_reg),
        .arg     (x_arg_reg),
        .sp      (sp_reg),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b),
        .ctl     (ctl),
        .alu_res (alu_res)
    );

    assign sp_m1 = sp_reg - SPW'(1);
    assign sp_m2 = sp_reg - SPW'(2);

    // write-back of the executing instruction
    assign wr_en = x_fire && ctl.wr_en;
    always_comb begin
        case (ctl.wr_addr_sel)
            smx_pkg::WA_SP2: wr_addr = sp_m2[AW-1:0];
            smx_pkg::WA_ARG: wr_addr = x_arg_reg[AW-1:0];
            default:         wr_addr = sp_reg[AW-1:0];
        endcase
        case (ctl.wr_data_sel)
            smx_pkg::WD_OPA: wr_data = opnd_a;
            smx_pkg::WD_ALU: wr_data = alu_res;
            default:         wr_data = smx_pkg::WORD_W'(x_arg_reg);
        endcase
    end

    assign pc_inc = (pc_reg == PCW'(PROGRAM_SIZE - 1)) ? '0 : pc_reg + PCW'(1);

    always_comb begin
        sp_next = sp_reg;
        pc_next = pc_reg;
        if (x_fire) begin
            case (ctl.sp_step)
                smx_pkg::SP_PUSH: sp_next = sp_reg + SPW'(1);
                smx_pkg::SP_POP:  sp_next = sp_m1;
                default:          sp_next = sp_reg;
            endcase
            case (ctl.pc_step)
                smx_pkg::PC_INC:  pc_next = pc_inc;
                smx_pkg::PC_JUMP: pc_next = x_arg_reg[PCW-1:0];
                default:          pc_next = pc_reg;
            endcase
        end
    end

    // reads of the entering instruction see the stack pointer it will run with
    assign sp_next_m1 = sp_next - SPW'(1);
    assign sp_next_m2 = sp_next - SPW'(2);
    assign rd_addr_a  = (smx_pkg::op_t'(s_op) == smx_pkg::OP_LOAD) ? s_arg[AW-1:0]
                                                                  : sp_next_m1[AW-1:0];
    assign rd_addr_b  = sp_next_m2[AW-1:0];

    smx_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack_ram (
        .aclk      (aclk),
        .rd_en     (s_fire),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            sp_reg      <= '0;
            pc_reg      <= '0;
        end else begin
            sp_reg <= sp_next;
            pc_reg <= pc_next;
            if (s_fire) begin
                x_valid_reg <= 1'b1;
            end else if (x_fire) begin
                x_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_op_reg     <= s_op;
            x_arg_reg    <= s_arg;
            fwd_a_reg    <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_reg    <= wr_en && (wr_addr == rd_addr_b);
            fwd_data_reg <= wr_data;
        end
    end

    assign print_value = ctl.print_valid ? smx_pkg::VALUE_W'(opnd_a) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (x_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (x_fire) begin
            m_tdata_reg <= {1'b0, ctl.fault, print_value, ctl.print_valid, ctl.halted,
                            smx_pkg::NEXT_PC_W'(pc_next)};
            m_tuser_reg <= ctl.print_is_bool;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
